FILE: hdl/spi_pkg.sv
`default_nettype none

package spi_pkg;

   // Field width of each coordinate on the stream and number of coordinates per word.
   localparam int FIELD_BITS = 32;
   localparam int NUM_COORDS = 8;

   // Pipeline control shared by the front and every divider cell: advance strobe and the stage's valid.
   typedef struct packed {
      logic en;
      logic vld;
   } stage_ctl_type;

endpackage

`default_nettype wire

FILE: hdl/spi_front.sv
`default_nettype none

module spi_front #(
   parameter int C = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire spi_pkg::stage_ctl_type ctl,
   input  wire logic [C-1:0]           coord [spi_pkg::NUM_COORDS],
   output logic                        vld_ff,
   output logic [2*C+2:0]              ad_ff,
   output logic [3*C+2:0]              anx_ff,
   output logic [3*C+2:0]              any_ff,
   output logic                        sx_ff,
   output logic                        sy_ff,
   output logic                        dz_ff,
   output logic [8*C-1:0]              box_ff
);
   import spi_pkg::*;

   localparam int AW = C + 1;
   localparam int MW = 2 * C + 1;
   localparam int PW = 2 * C + 2;
   localparam int DW = 2 * C + 3;
   localparam int NW = 3 * C + 3;

   // stage 1: differences, endpoint products, boxes
   logic signed [C-1:0]    crd [NUM_COORDS];
   logic signed [AW-1:0]   a1_in [2], b1_in [2], a1_ff [2], b1_ff [2];
   logic signed [2*C-1:0]  p1_in [2], q1_in [2], p1_ff [2], q1_ff [2];
   logic [8*C-1:0]         box1_in, box1_ff;
   logic                   vld1_ff;

   // stage 2: line coefficients with vertical fix
   logic signed [AW-1:0]   a2_in [2], b2_in [2], a2_ff [2], b2_ff [2];
   logic signed [MW-1:0]   m2_in [2], m2_ff [2];
   logic [8*C-1:0]         box2_ff;
   logic                   vld2_ff;

   // stage 3: partial products
   logic signed [AW-1:0]   mh [2], ml [2];
   logic signed [PW-1:0]   pnx_in [4], pny_in [4], pd_in [2];
   logic signed [PW-1:0]   pnx_ff [4], pny_ff [4], pd_ff [2];
   logic [8*C-1:0]         box3_ff;
   logic                   vld3_ff;

   // stage 4: numerators and denominator
   logic signed [NW-1:0]   nx_in, ny_in, nx_ff, ny_ff;
   logic signed [DW-1:0]   d_in, d_ff;
   logic [8*C-1:0]         box4_ff;
   logic                   vld4_ff;

   // stage 5: magnitudes and signs
   logic                   dneg;

   always_comb begin
      for (int i = 0; i < NUM_COORDS; i++) begin
         crd[i] = $signed(coord[i]);
      end
   end

   for (genvar j = 0; j < 2; j++) begin : g_seg
      logic signed [C-1:0] ax, ay, bx, by;
      assign ax = crd[4*j];
      assign ay = crd[4*j+1];
      assign bx = crd[4*j+2];
      assign by = crd[4*j+3];
      assign a1_in[j] = AW'(ay) - AW'(by);
      assign b1_in[j] = AW'(ax) - AW'(bx);
      assign p1_in[j] = ax * by;
      assign q1_in[j] = bx * ay;
      assign box1_in[(4*j)*C   +: C] = (ax < bx) ? ax : bx;
      assign box1_in[(4*j+1)*C +: C] = (ax < bx) ? bx : ax;
      assign box1_in[(4*j+2)*C +: C] = (ay < by) ? ay : by;
      assign box1_in[(4*j+3)*C +: C] = (ay < by) ? by : ay;

      // a vertical or degenerate segment stands for the line y = 0
      always_comb begin
         if (b1_ff[j] == '0) begin
            a2_in[j] = '0;
            b2_in[j] = AW'(1);
            m2_in[j] = '0;
         end else begin
            a2_in[j] = a1_ff[j];
            b2_in[j] = b1_ff[j];
            m2_in[j] = MW'(p1_ff[j]) - MW'(q1_ff[j]);
         end
      end

      // intercept split so that each product stays near one operand width
      assign mh[j] = $signed(m2_ff[j][MW-1:C]);
      assign ml[j] = $signed({1'b0, m2_ff[j][C-1:0]});
   end

   // index 0 is the first segment, index 1 the second
   assign pnx_in[0] = mh[1] * b2_ff[0];
   assign pnx_in[1] = ml[1] * b2_ff[0];
   assign pnx_in[2] = mh[0] * b2_ff[1];
   assign pnx_in[3] = ml[0] * b2_ff[1];
   assign pny_in[0] = a2_ff[0] * mh[1];
   assign pny_in[1] = a2_ff[0] * ml[1];
   assign pny_in[2] = a2_ff[1] * mh[0];
   assign pny_in[3] = a2_ff[1] * ml[0];
   assign pd_in[0]  = a2_ff[0] * b2_ff[1];
   assign pd_in[1]  = a2_ff[1] * b2_ff[0];

   assign nx_in = ((NW'(pnx_ff[0]) <<< C) + NW'(pnx_ff[1]))
                - ((NW'(pnx_ff[2]) <<< C) + NW'(pnx_ff[3]));
   assign ny_in = ((NW'(pny_ff[0]) <<< C) + NW'(pny_ff[1]))
                - ((NW'(pny_ff[2]) <<< C) + NW'(pny_ff[3]));
   assign d_in  = DW'(pd_ff[0]) - DW'(pd_ff[1]);

   assign dneg = d_ff[DW-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
         vld_ff  <= 1'b0;
      end else if (ctl.en) begin
         vld1_ff <= ctl.vld;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
         vld_ff  <= vld4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         a1_ff   <= a1_in;
         b1_ff   <= b1_in;
         p1_ff   <= p1_in;
         q1_ff   <= q1_in;
         box1_ff <= box1_in;
         a2_ff   <= a2_in;
         b2_ff   <= b2_in;
         m2_ff   <= m2_in;
         box2_ff <= box1_ff;
         pnx_ff  <= pnx_in;
         pny_ff  <= pny_in;
         pd_ff   <= pd_in;
         box3_ff <= box2_ff;
         nx_ff   <= nx_in;
         ny_ff   <= ny_in;
         d_ff    <= d_in;
         box4_ff <= box3_ff;
         ad_ff   <= dneg ? DW'(-d_ff) : DW'(d_ff);
         anx_ff  <= nx_ff[NW-1] ? NW'(-nx_ff) : NW'(nx_ff);
         any_ff  <= ny_ff[NW-1] ? NW'(-ny_ff) : NW'(ny_ff);
         sx_ff   <= nx_ff[NW-1] ^ dneg;
         sy_ff   <= ny_ff[NW-1] ^ dneg;
         dz_ff   <= (d_ff == '0);
         box_ff  <= box4_ff;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/spi_div_cell.sv
`default_nettype none

module spi_div_cell #(
   parameter int C    = 32,
   parameter int NW   = 99,
   parameter int DW   = 67,
   parameter int SW   = 260,
   parameter int STEP = 0
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire spi_pkg::stage_ctl_type ctl,
   input  wire logic [NW-1:0]          rem_x,
   input  wire logic [NW-1:0]          rem_y,
   input  wire logic [C-1:0]           quo_x,
   input  wire logic [C-1:0]           quo_y,
   input  wire logic [DW-1:0]          div,
   input  wire logic [SW-1:0]          side,
   output logic                        vld_ff,
   output logic [NW-1:0]               rem_x_ff,
   output logic [NW-1:0]               rem_y_ff,
   output logic [C-1:0]                quo_x_ff,
   output logic [C-1:0]                quo_y_ff,
   output logic [DW-1:0]               div_ff,
   output logic [SW-1:0]               side_ff
);
   import spi_pkg::*;

   logic [NW-1:0] dsh;
   logic          take_x, take_y;
   logic [NW-1:0] rem_x_in, rem_y_in;
   logic [C-1:0]  quo_x_in, quo_y_in;

   // one restoring step on both lanes against the shared divisor
   assign dsh    = NW'(div) << STEP;
   assign take_x = (rem_x >= dsh);
   assign take_y = (rem_y >= dsh);

   always_comb begin
      rem_x_in       = take_x ? rem_x - dsh : rem_x;
      rem_y_in       = take_y ? rem_y - dsh : rem_y;
      quo_x_in       = quo_x;
      quo_y_in       = quo_y;
      quo_x_in[STEP] = take_x;
      quo_y_in[STEP] = take_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (ctl.en) begin
         vld_ff <= ctl.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         rem_x_ff <= rem_x_in;
         rem_y_ff <= rem_y_in;
         quo_x_ff <= quo_x_in;
         quo_y_ff <= quo_y_in;
         div_ff   <= div;
         side_ff  <= side;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/segment_pair_intersection.sv
`default_nettype none

// Intersection of two line segments, one pair per word, one word per cycle while results are taken.
// Each segment is turned into line-coefficient form, the exact rational crossing
// point is found, and a hit is flagged when it lies inside both segments'
// inclusive boxes; the coordinates come out truncated toward zero (zero on a
// miss). The pipe is five arithmetic stages, a row of
// COORD_BITS divider cells (one quotient bit each, x and y side by side) and
// the output register. The whole pipe holds while a result is not taken, so a
// new word is accepted in any cycle the output register is empty or draining.
// Only the low COORD_BITS bits of each input coordinate are used.
module segment_pair_intersection #(
   parameter int COORD_BITS = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // first_ax, first_ay, first_bx, first_by, second_ax, second_ay, second_bx, second_by
   input  wire logic [255:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // cross_x, cross_y
   output logic [63:0]       rsp_tdata,
   // hit
   output logic [0:0]        rsp_tuser
);
   import spi_pkg::*;

   localparam int C  = COORD_BITS;
   localparam int DW = 2 * C + 3;
   localparam int NW = 3 * C + 3;
   localparam int SW = 8 * C + 4;

   logic          en;
   stage_ctl_type ctl_front;
   stage_ctl_type ctl_cell [C];
   logic [C-1:0]  coord [NUM_COORDS];

   logic          f_vld, f_sx, f_sy, f_dz, f_ov;
   logic [DW-1:0] f_ad;
   logic [NW-1:0] f_anx, f_any;
   logic [8*C-1:0] f_box;

   logic          ch_vld [C+1];
   logic [NW-1:0] ch_rx [C+1], ch_ry [C+1];
   logic [C-1:0]  ch_qx [C+1], ch_qy [C+1];
   logic [DW-1:0] ch_d [C+1];
   logic [SW-1:0] ch_side [C+1];

   logic [8*C-1:0]       e_box;
   logic                 e_sx, e_sy, e_dz, e_ov;
   logic signed [C+1:0]  qxe, qye, flx, cex, fly, cey, xo, yo;
   logic signed [C+1:0]  bnd [8];
   logic                 rnx, rny, hit_in;
   logic [31:0]          cx_in, cy_in;

   logic                 rsp_vld_ff, hit_ff;
   logic [31:0]          cx_ff, cy_ff;

   assign en         = !rsp_vld_ff || rsp_tready;
   assign req_tready = en;
   assign ctl_front  = '{en: en, vld: req_tvalid};

   for (genvar i = 0; i < NUM_COORDS; i++) begin : g_crd
      assign coord[i] = C'(req_tdata[FIELD_BITS*i +: FIELD_BITS]);
   end

   spi_front #(.C(C)) u_front (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl_front),
      .coord  (coord),
      .vld_ff (f_vld),
      .ad_ff  (f_ad),
      .anx_ff (f_anx),
      .any_ff (f_any),
      .sx_ff  (f_sx),
      .sy_ff  (f_sy),
      .dz_ff  (f_dz),
      .box_ff (f_box)
   );

   // a quotient that needs more than C bits is outside every box anyway
   assign f_ov = (f_anx >= (NW'(f_ad) << C)) || (f_any >= (NW'(f_ad) << C));

   assign ch_vld[0]  = f_vld;
   assign ch_rx[0]   = f_anx;
   assign ch_ry[0]   = f_any;
   assign ch_qx[0]   = '0;
   assign ch_qy[0]   = '0;
   assign ch_d[0]    = f_ad;
   assign ch_side[0] = {f_box, f_sx, f_sy, f_dz, f_ov};

   for (genvar k = 0; k < C; k++) begin : g_cell
      assign ctl_cell[k] = '{en: en, vld: ch_vld[k]};
      spi_div_cell #(.C(C), .NW(NW), .DW(DW), .SW(SW), .STEP(C-1-k)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl_cell[k]),
         .rem_x    (ch_rx[k]),
         .rem_y    (ch_ry[k]),
         .quo_x    (ch_qx[k]),
         .quo_y    (ch_qy[k]),
         .div      (ch_d[k]),
         .side     (ch_side[k]),
         .vld_ff   (ch_vld[k+1]),
         .rem_x_ff (ch_rx[k+1]),
         .rem_y_ff (ch_ry[k+1]),
         .quo_x_ff (ch_qx[k+1]),
         .quo_y_ff (ch_qy[k+1]),
         .div_ff   (ch_d[k+1]),
         .side_ff  (ch_side[k+1])
      );
   end

   assign {e_box, e_sx, e_sy, e_dz, e_ov} = ch_side[C];

   for (genvar b = 0; b < 8; b++) begin : g_bnd
      assign bnd[b] = (C+2)'($signed(e_box[b*C +: C]));
   end

   // floor and ceiling of the exact point from quotient, remainder and sign
   assign qxe = $signed({2'b00, ch_qx[C]});
   assign qye = $signed({2'b00, ch_qy[C]});
   assign rnx = (ch_rx[C] != '0);
   assign rny = (ch_ry[C] != '0);
   assign xo  = e_sx ? -qxe : qxe;
   assign yo  = e_sy ? -qye : qye;
   assign flx = e_sx ? xo - (C+2)'(rnx) : xo;
   assign cex = e_sx ? xo : xo + (C+2)'(rnx);
   assign fly = e_sy ? yo - (C+2)'(rny) : yo;
   assign cey = e_sy ? yo : yo + (C+2)'(rny);

   assign hit_in = !e_dz && !e_ov
                && (flx >= bnd[0]) && (cex <= bnd[1])
                && (fly >= bnd[2]) && (cey <= bnd[3])
                && (flx >= bnd[4]) && (cex <= bnd[5])
                && (fly >= bnd[6]) && (cey <= bnd[7]);
   assign cx_in  = hit_in ? 32'(xo) : '0;
   assign cy_in  = hit_in ? 32'(yo) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= ch_vld[C];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff <= hit_in;
         cx_ff  <= cx_in;
         cy_ff  <= cy_in;
      end
   end

   assign rsp_tvalid   = rsp_vld_ff;
   assign rsp_tdata    = {cy_ff, cx_ff};
   assign rsp_tuser[0] = hit_ff;

   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("miss word carries nonzero coordinates");

   a_stall_only : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input held off without a stalled result");

   a_no_false_hit : assert property (@(posedge clock) disable iff (reset)
      en && ch_vld[C] && (e_dz || e_ov) |=> !rsp_tuser[0])
      else $error("hit flagged for parallel lines or out-of-range quotient");

endmodule

`default_nettype wire
